### rtl/text_terminal_cell_engine_macros.svh
// Assertion macros used by the checker file.
`ifndef TEXT_TERMINAL_CELL_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_CELL_ENGINE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TTCE_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define TTCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ttce_pkg.sv
package ttce_pkg;

  // Grid geometry
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CCNT_W   = $clog2(MAX_COLS + 1);
  localparam int RCNT_W   = $clog2(MAX_ROWS + 1);

  // Configuration register widths and reset values
  localparam int CFG_COLS_W = 8;
  localparam int CFG_ROWS_W = 7;
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 8'd80;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 7'd25;

  // Compare widths that hold both a register value and a clamped size
  localparam int CCMP_W = (CCNT_W > CFG_COLS_W) ? CCNT_W : CFG_COLS_W;
  localparam int RCMP_W = (RCNT_W > CFG_ROWS_W) ? RCNT_W : CFG_ROWS_W;

  // Tab stops
  localparam int TAB_STEP = 4;
  localparam int TAB_LOG  = $clog2(TAB_STEP);
  localparam int TAB_W    = $clog2(TAB_STEP + 1);

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Bus
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [0:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CK_NL    = 3'd0,
    CK_CR    = 3'd1,
    CK_TAB   = 3'd2,
    CK_BS    = 3'd3,
    CK_OTHER = 3'd4
  } ch_kind_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } op_item_t;

  typedef struct packed {
    logic [7:0] cell_value;
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic       scrolled;
  } res_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic clamp;
    logic clear_all;
    logic rd_cell;
    logic line_feed;
    logic car_ret;
    logic put_load;
    logic back_space;
    logic store;
    logic fill;
    logic fill_scr;
    logic scr_rd;
    logic scr_wr;
    logic scr_next;
    logic scr_done;
    logic res_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    opcode_t  opcode;
    ch_kind_t ch_kind;
    logic     col_zero;
    logic     col_last;
    logic     row_last;
    logic     row_ok;
    logic     store_space;
    logic     tab_more;
    logic     tab_pending;
    logic     fill_last;
    logic     dst_ok;
    logic     src_ok;
    logic     sc_last;
    logic     sr_last;
  } dp_stat_t;

endpackage

### rtl/ttce_datapath.sv
module ttce_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ttce_pkg::CFG_COLS_W-1:0]     cfg_cols,
  input  logic [ttce_pkg::CFG_ROWS_W-1:0]     cfg_rows,
  input  ttce_pkg::op_item_t                  op_item,
  input  ttce_pkg::dp_cmd_t                   cmd,
  output ttce_pkg::dp_stat_t                  stat,
  output ttce_pkg::res_item_t                 res_item
);

  localparam int ADDR_W = $clog2(ttce_pkg::MAX_ROWS * ttce_pkg::MAX_COLS);
  localparam int DEPTH  = ttce_pkg::MAX_ROWS * ttce_pkg::MAX_COLS;

  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [ttce_pkg::ROW_W-1:0] r,
    input logic [ttce_pkg::COL_W-1:0] c
  );
    return ADDR_W'(r) * ADDR_W'(ttce_pkg::MAX_COLS) + ADDR_W'(c);
  endfunction

  // Cell memory
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  // Item, cursor and sequencing registers
  ttce_pkg::op_item_t              item_q;
  logic [ttce_pkg::COL_W-1:0]      cur_col;
  logic [ttce_pkg::ROW_W-1:0]      cur_row;
  logic [ttce_pkg::TAB_W-1:0]      tab_cnt;
  logic [7:0]                      store_ch;
  logic                            did_scroll;
  logic [ttce_pkg::COL_W-1:0]      fc;
  logic [ttce_pkg::COL_W-1:0]      sc;
  logic [ttce_pkg::ROW_W-1:0]      sr;
  logic [ttce_pkg::MAX_ROWS-1:0]   row_valid;

  // Derived values
  logic [ttce_pkg::CCMP_W-1:0]     cols_x;
  logic [ttce_pkg::RCMP_W-1:0]     rows_x;
  logic [ttce_pkg::CCNT_W-1:0]     cols_eff;
  logic [ttce_pkg::RCNT_W-1:0]     rows_eff;
  logic [ttce_pkg::ROW_W-1:0]      sr_p1;
  logic [ttce_pkg::ROW_W-1:0]      fill_row;
  logic [ttce_pkg::ROW_W-1:0]      rd_row_idx;
  logic                            is_tab;
  logic                            col_last;
  logic                            row_last;
  logic                            fill_last;
  logic                            sc_last;
  logic                            sr_last;
  logic                            src_ok;
  logic                            rd_in_range;
  logic [7:0]                      rd_cell_value;

  logic                            we;
  logic [ADDR_W-1:0]               wa;
  logic [7:0]                      wd;
  logic                            re;
  logic [ADDR_W-1:0]               ra;

  // Clamp the configured sizes
  assign cols_x   = ttce_pkg::CCMP_W'(cfg_cols);
  assign rows_x   = ttce_pkg::RCMP_W'(cfg_rows);
  assign cols_eff = (cols_x == '0) ? ttce_pkg::CCNT_W'(1) :
                    (cols_x > ttce_pkg::CCMP_W'(ttce_pkg::MAX_COLS)) ?
                    ttce_pkg::CCNT_W'(ttce_pkg::MAX_COLS) : ttce_pkg::CCNT_W'(cols_x);
  assign rows_eff = (rows_x == '0) ? ttce_pkg::RCNT_W'(1) :
                    (rows_x > ttce_pkg::RCMP_W'(ttce_pkg::MAX_ROWS)) ?
                    ttce_pkg::RCNT_W'(ttce_pkg::MAX_ROWS) : ttce_pkg::RCNT_W'(rows_x);

  // Position flags
  assign is_tab    = (item_q.char_code == ttce_pkg::CH_TAB);
  assign col_last  = (ttce_pkg::CCNT_W'(cur_col) + ttce_pkg::CCNT_W'(1)) >= cols_eff;
  assign row_last  = (ttce_pkg::RCNT_W'(cur_row) + ttce_pkg::RCNT_W'(1)) >= rows_eff;
  assign fill_last = (fc == ttce_pkg::COL_W'(ttce_pkg::MAX_COLS - 1));
  assign sc_last   = (ttce_pkg::CCNT_W'(sc) + ttce_pkg::CCNT_W'(1)) == cols_eff;
  assign sr_last   = (ttce_pkg::RCNT_W'(sr) + ttce_pkg::RCNT_W'(1)) == rows_eff;
  assign sr_p1     = sr + ttce_pkg::ROW_W'(1);
  // The row below feeds the copy only while it lies inside the screen
  assign src_ok    = !sr_last && row_valid[sr_p1];
  assign fill_row  = cmd.fill_scr ? sr : cur_row;

  // Status towards the controller
  always_comb begin
    stat.opcode = item_q.opcode;
    unique case (item_q.char_code)
      ttce_pkg::CH_NL:  stat.ch_kind = ttce_pkg::CK_NL;
      ttce_pkg::CH_CR:  stat.ch_kind = ttce_pkg::CK_CR;
      ttce_pkg::CH_TAB: stat.ch_kind = ttce_pkg::CK_TAB;
      ttce_pkg::CH_BS:  stat.ch_kind = ttce_pkg::CK_BS;
      default:          stat.ch_kind = ttce_pkg::CK_OTHER;
    endcase
    stat.col_zero    = (cur_col == '0);
    stat.col_last    = col_last;
    stat.row_last    = row_last;
    stat.row_ok      = row_valid[cur_row];
    stat.store_space = (store_ch == ttce_pkg::CH_SPACE);
    stat.tab_more    = (tab_cnt > ttce_pkg::TAB_W'(1));
    stat.tab_pending = (tab_cnt != '0);
    stat.fill_last   = fill_last;
    stat.dst_ok      = row_valid[sr];
    stat.src_ok      = src_ok;
    stat.sc_last     = sc_last;
    stat.sr_last     = sr_last;
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= op_item;
    end
  end

  // Cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.clear_all) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.clamp) begin
      if (ttce_pkg::CCNT_W'(cur_col) >= cols_eff) begin
        cur_col <= ttce_pkg::COL_W'(cols_eff - ttce_pkg::CCNT_W'(1));
      end
      if (ttce_pkg::RCNT_W'(cur_row) >= rows_eff) begin
        cur_row <= ttce_pkg::ROW_W'(rows_eff - ttce_pkg::RCNT_W'(1));
      end
    end else if (cmd.line_feed) begin
      cur_col <= '0;
      if (!row_last) begin
        cur_row <= cur_row + ttce_pkg::ROW_W'(1);
      end
    end else if (cmd.car_ret) begin
      cur_col <= '0;
    end else if (cmd.back_space) begin
      cur_col <= cur_col - ttce_pkg::COL_W'(1);
    end else if (cmd.store) begin
      if (col_last) begin
        cur_col <= '0;
        if (!row_last) begin
          cur_row <= cur_row + ttce_pkg::ROW_W'(1);
        end
      end else begin
        cur_col <= cur_col + ttce_pkg::COL_W'(1);
      end
    end else if (cmd.scr_done) begin
      cur_row <= ttce_pkg::ROW_W'(rows_eff - ttce_pkg::RCNT_W'(1));
    end
  end

  // Pending stores of the current put and the byte they write
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_cnt <= '0;
    end else if (cmd.put_load) begin
      tab_cnt <= is_tab ?
                 ttce_pkg::TAB_W'(ttce_pkg::TAB_STEP) -
                 ttce_pkg::TAB_W'(cur_col[ttce_pkg::TAB_LOG-1:0]) :
                 ttce_pkg::TAB_W'(1);
    end else if (cmd.store) begin
      tab_cnt <= tab_cnt - ttce_pkg::TAB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_load) begin
      store_ch <= is_tab ? ttce_pkg::CH_SPACE : item_q.char_code;
    end
  end

  // Scroll flag for the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      did_scroll <= 1'b0;
    end else if (cmd.capture) begin
      did_scroll <= 1'b0;
    end else if (cmd.scr_done) begin
      did_scroll <= 1'b1;
    end
  end

  // Sweep counters; each returns to zero when its sweep ends
  always_ff @(posedge clk) begin
    if (rst) begin
      fc <= '0;
      sc <= '0;
      sr <= '0;
    end else begin
      if (cmd.fill) begin
        fc <= fill_last ? '0 : fc + ttce_pkg::COL_W'(1);
      end
      if (cmd.scr_wr) begin
        sc <= sc_last ? '0 : sc + ttce_pkg::COL_W'(1);
      end
      if (cmd.scr_done) begin
        sr <= '0;
      end else if (cmd.scr_next) begin
        sr <= sr_p1;
      end
    end
  end

  // Row valid bits: an invalid row reads as all spaces
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.clear_all) begin
      row_valid <= '0;
    end else if (cmd.fill && fill_last) begin
      row_valid[fill_row] <= 1'b1;
    end
  end

  // Memory write port select
  always_comb begin
    we = 1'b0;
    wa = cell_addr(cur_row, cur_col);
    wd = ttce_pkg::CH_SPACE;
    if (cmd.fill) begin
      we = 1'b1;
      wa = cell_addr(fill_row, fc);
    end else if (cmd.store) begin
      we = row_valid[cur_row];
      wd = store_ch;
    end else if (cmd.back_space) begin
      we = row_valid[cur_row];
      wa = cell_addr(cur_row, cur_col - ttce_pkg::COL_W'(1));
    end else if (cmd.scr_wr) begin
      we = 1'b1;
      wa = cell_addr(sr, sc);
      wd = src_ok ? rd_data : ttce_pkg::CH_SPACE;
    end
  end

  // Memory read port select
  assign rd_row_idx = ttce_pkg::ROW_W'(item_q.read_row);
  assign re = cmd.rd_cell || cmd.scr_rd;
  assign ra = cmd.scr_rd ? cell_addr(sr_p1, sc) :
              cell_addr(rd_row_idx, ttce_pkg::COL_W'(item_q.read_col));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  // Result assembly
  assign rd_in_range =
    (ttce_pkg::RCMP_W'(item_q.read_row) < ttce_pkg::RCMP_W'(rows_eff)) &&
    (ttce_pkg::CCMP_W'(item_q.read_col) < ttce_pkg::CCMP_W'(cols_eff));
  assign rd_cell_value = (rd_in_range && row_valid[rd_row_idx]) ? rd_data : ttce_pkg::CH_SPACE;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_item.cell_value <= (item_q.opcode == ttce_pkg::OP_READ) ? rd_cell_value : 8'h00;
      res_item.cursor_col <= 7'(cur_col);
      res_item.cursor_row <= 6'(cur_row);
      res_item.scrolled   <= did_scroll;
    end
  end

endmodule

### rtl/ttce_ctrl.sv
module ttce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  output logic               res_valid,
  input  logic               res_ready,
  input  ttce_pkg::dp_stat_t stat,
  output ttce_pkg::dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISP     = 10'b0000000010,
    S_PUT      = 10'b0000000100,
    S_STORE    = 10'b0000001000,
    S_FILL_CUR = 10'b0000010000,
    S_SCR_ROW  = 10'b0000100000,
    S_FILL_SCR = 10'b0001000000,
    S_SCR_RD   = 10'b0010000000,
    S_SCR_WR   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_scroll;

  assign op_ready     = (state == S_IDLE);
  assign after_scroll = stat.tab_pending ? S_STORE : S_DONE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (op_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.opcode)
          ttce_pkg::OP_PUT: begin
            cmd.clamp  = 1'b1;
            state_next = S_PUT;
          end
          ttce_pkg::OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = S_DONE;
          end
          ttce_pkg::OP_READ: begin
            cmd.rd_cell = 1'b1;
            state_next  = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_PUT: begin
        case (stat.ch_kind)
          ttce_pkg::CK_NL: begin
            cmd.line_feed = 1'b1;
            state_next    = stat.row_last ? S_SCR_ROW : S_DONE;
          end
          ttce_pkg::CK_CR: begin
            cmd.car_ret = 1'b1;
            state_next  = S_DONE;
          end
          ttce_pkg::CK_BS: begin
            cmd.back_space = !stat.col_zero;
            state_next     = S_DONE;
          end
          default: begin
            cmd.put_load = 1'b1;
            state_next   = S_STORE;
          end
        endcase
      end
      S_STORE: begin
        // Blank the row first when a visible byte lands in a cleared row
        if (!stat.row_ok && !stat.store_space) begin
          state_next = S_FILL_CUR;
        end else begin
          cmd.store = 1'b1;
          if (stat.col_last && stat.row_last) begin
            state_next = S_SCR_ROW;
          end else if (stat.tab_more) begin
            state_next = S_STORE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FILL_CUR: begin
        cmd.fill = 1'b1;
        if (stat.fill_last) begin
          state_next = S_STORE;
        end
      end
      S_SCR_ROW: begin
        if (!stat.dst_ok && !stat.src_ok) begin
          // Both rows blank: nothing moves
          if (stat.sr_last) begin
            cmd.scr_done = 1'b1;
            state_next   = after_scroll;
          end else begin
            cmd.scr_next = 1'b1;
          end
        end else if (!stat.dst_ok) begin
          state_next = S_FILL_SCR;
        end else begin
          state_next = S_SCR_RD;
        end
      end
      S_FILL_SCR: begin
        cmd.fill     = 1'b1;
        cmd.fill_scr = 1'b1;
        if (stat.fill_last) begin
          state_next = S_SCR_ROW;
        end
      end
      S_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        if (stat.sc_last) begin
          if (stat.sr_last) begin
            cmd.scr_done = 1'b1;
            state_next   = after_scroll;
          end else begin
            cmd.scr_next = 1'b1;
            state_next   = S_SCR_ROW;
          end
        end else begin
          state_next = S_SCR_RD;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!res_valid || res_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

### rtl/text_terminal_cell_engine.sv
// Items are handled one at a time: a new item is taken only once the result of the last
//   has been loaded into the output register. A tab stores spaces up to the next tab stop;
//   the first visible write to a row since clear blanks the whole row first, and a scroll
//   moves every row up by one, blanking a cleared destination row first.
// Reset: synchronous; cursor homes, sizes return to 80 x 25, row valid bits clear at once.
module text_terminal_cell_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttce_pkg::PADDR_W-1:0]  paddr,
  input  logic [ttce_pkg::PDATA_W-1:0]  pwdata,
  output logic [ttce_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  ttce_pkg::op_item_t            op_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ttce_pkg::res_item_t           res_item
);

  logic [ttce_pkg::CFG_COLS_W-1:0] cfg_cols;
  logic [ttce_pkg::CFG_ROWS_W-1:0] cfg_rows;
  ttce_pkg::reg_idx_t              reg_idx;
  ttce_pkg::dp_cmd_t               cmd;
  ttce_pkg::dp_stat_t              stat;

  assign pready  = 1'b1;
  assign reg_idx = ttce_pkg::reg_idx_t'(paddr[2]);

  // Size registers, written on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols <= ttce_pkg::COLS_RESET;
      cfg_rows <= ttce_pkg::ROWS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        ttce_pkg::REG_COLUMNS: cfg_cols <= pwdata[ttce_pkg::CFG_COLS_W-1:0];
        ttce_pkg::REG_ROWS:    cfg_rows <= pwdata[ttce_pkg::CFG_ROWS_W-1:0];
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      ttce_pkg::REG_COLUMNS: prdata = ttce_pkg::PDATA_W'(cfg_cols);
      ttce_pkg::REG_ROWS:    prdata = ttce_pkg::PDATA_W'(cfg_rows);
    endcase
  end

  ttce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttce_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_cols (cfg_cols),
    .cfg_rows (cfg_rows),
    .op_item  (op_item),
    .cmd      (cmd),
    .stat     (stat),
    .res_item (res_item)
  );

endmodule

### rtl/ttce_checker.sv
`include "text_terminal_cell_engine_macros.svh"

module ttce_checker (
  input logic                clk,
  input logic                rst,
  input logic                op_valid,
  input logic                op_ready,
  input logic                res_valid,
  input logic                res_ready,
  input ttce_pkg::res_item_t res_item
);

  // A stalled result holds
  `TTCE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item), "result changed while stalled")

  // One item at a time: the input closes after each transfer
  `TTCE_ASSERT_NEXT(a_one_item, op_valid && op_ready, !op_ready, "input open straight after a transfer")

  // Only puts scroll, and they report no cell value
  `TTCE_ASSERT_NOW(a_scroll_cell, !(res_valid && res_item.scrolled) || (res_item.cell_value == 8'h00), "scrolled result carries a cell value")

  // After a scroll the cursor sits within the first tab stop
  `TTCE_ASSERT_NOW(a_scroll_col, !(res_valid && res_item.scrolled) || (res_item.cursor_col < 7'(ttce_pkg::TAB_STEP)), "cursor too far right after a scroll")

endmodule

bind text_terminal_cell_engine ttce_checker u_ttce_checker (.*);
